// ===== src/trd_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// trd_pkg: shared types and helpers of the tandem repeat detector
// Detector state, result beat layout, config register indexes and the
// saturating and field-select helpers used by the step logic.
// ---------------------------------------------------------------------------
package trd_pkg;

    localparam int unsigned MEGABASE_LIMIT = 1000000;
    localparam int unsigned GPOS_W         = 21;
    localparam int unsigned HIST_DEPTH     = 12;
    localparam int unsigned MIN_PERIOD     = 2;
    localparam int unsigned MAX_PERIOD     = 6;
    localparam int unsigned CFG_W          = 40;

    localparam logic [30:0] SAT31        = {31{1'b1}};
    localparam logic [8:0]  MISMATCH_MAX = 9'd511;

    localparam logic [7:0] CHAR_HEADER  = 8'h3E;   // '>'
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;   // '\n'
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] CHAR_A       = 8'h61;
    localparam logic [7:0] CHAR_C       = 8'h63;
    localparam logic [7:0] CHAR_G       = 8'h67;
    localparam logic [7:0] CHAR_T       = 8'h74;

    // History slot codes: 0 empty, 1..4 = a,c,g,t
    localparam logic [2:0] HIST_EMPTY = 3'd0;
    localparam logic [2:0] HIST_A     = 3'd1;
    localparam logic [2:0] HIST_C     = 3'd2;
    localparam logic [2:0] HIST_G     = 3'd3;
    localparam logic [2:0] HIST_T     = 3'd4;

    // Config register indexes
    localparam logic CFG_MIN_REPEATS = 1'b0;
    localparam logic CFG_SKIP_TOL    = 1'b1;

    localparam logic [CFG_W-1:0] MIN_REPEATS_RESET = 40'd21559051525;
    localparam logic [CFG_W-1:0] SKIP_TOL_RESET    = 40'd0;

    typedef logic [2:0] hist_code_t;

    typedef enum logic {
        EV_OPEN   = 1'b0,
        EV_EXTEND = 1'b1
    } trd_event_t;

    typedef struct packed {
        hist_code_t [HIST_DEPTH-1:0] hist;      // [0] is the newest base
        logic                        in_header;
        logic [31:0]                 rec_pos;
        logic [GPOS_W-1:0]           gen_pos;
        logic [30:0]                 megabases;
        logic                        run_active;
        logic [2:0]                  run_period;
        logic [11:0]                 run_motif;
        logic [30:0]                 match_count;
        logic [2:0]                  phase_count;
        logic [8:0]                  mismatch_count;
        logic [31:0]                 locus_start;
        logic [30:0]                 locus_length;
        logic [30:0]                 content_total;
    } trd_state_t;

    typedef struct packed {
        trd_event_t  kind;
        logic [2:0]  period;
        logic [11:0] motif;
        logic [31:0] start;
        logic [30:0] length;
        logic [30:0] content;
        logic [30:0] megabases;
    } trd_result_t;

    function automatic logic [30:0] sat_add31(input logic [30:0] a, input logic [30:0] b);
        logic [31:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[31] ? SAT31 : s[30:0];
    endfunction

    // Byte of a packed per-period register, period 2 in the low byte
    function automatic logic [7:0] field_byte(input logic [CFG_W-1:0] vec,
                                              input logic [2:0] p);
        logic [7:0] b;
        case (p)
            3'd2:    b = vec[7:0];
            3'd3:    b = vec[15:8];
            3'd4:    b = vec[23:16];
            3'd5:    b = vec[31:24];
            3'd6:    b = vec[39:32];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic hist_code_t base_code(input logic [7:0] c);
        hist_code_t h;
        case (c)
            CHAR_A:  h = HIST_A;
            CHAR_C:  h = HIST_C;
            CHAR_G:  h = HIST_G;
            CHAR_T:  h = HIST_T;
            default: h = HIST_EMPTY;
        endcase
        return h;
    endfunction

endpackage
`default_nettype wire

// ===== src/trd_step.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// trd_step: next-state and result logic for one text byte
// Parallel period compares over the shifted history, run tracking and
// locus reporting; purely combinational.
// ---------------------------------------------------------------------------
module trd_step
    import trd_pkg::*;
(
    input  wire logic [7:0]       char_code,
    input  wire trd_state_t       st,
    input  wire logic [CFG_W-1:0] min_repeats,
    input  wire logic [CFG_W-1:0] skip_tol,
    output      trd_state_t       st_next,
    output      logic             res_valid,
    output      trd_result_t      res
);

    logic [7:0]                  c;
    hist_code_t                  code;
    hist_code_t [HIST_DEPTH-1:0] hist_new;
    logic [6:2]                  same_v;
    logic [6:2]                  rep_v;
    logic [6:2][11:0]            motif_v;
    logic [2:0]                  p;
    logic [2:0]                  phase_inc;
    logic [7:0]                  mr;
    logic [7:0]                  mr_cl;
    logic [10:0]                 content_inc;
    logic [10:0]                 start_back;
    logic [8:0]                  mism;

    assign c = (char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_Z) ?
               char_code + CASE_OFFSET : char_code;
    assign code     = base_code(c);
    assign hist_new = {st.hist[HIST_DEPTH-2:0], code};

    // Per-period compares, all periods in parallel
    always_comb begin
        hist_code_t t;
        same_v  = '1;
        rep_v   = '1;
        motif_v = '0;
        for (int q = MIN_PERIOD; q <= MAX_PERIOD; q++) begin
            for (int j = 0; j < q; j++) begin
                // stored motif against the previous unit
                if (hist_new[q+j] != ({1'b0, st.run_motif[2*(q-1-j) +: 2]} + 3'd1))
                    same_v[q] = 1'b0;
                // two equal units at the newest end
                if (hist_new[j] != hist_new[j+q])
                    rep_v[q] = 1'b0;
                t = hist_new[q-1-j] - 3'd1;
                motif_v[q][2*j +: 2] = t[1:0];
            end
        end
    end

    assign p           = st.run_period;
    assign phase_inc   = st.phase_count + 3'd1;
    assign mr          = field_byte(min_repeats, p);
    assign mr_cl       = (mr < 8'd2) ? 8'd2 : mr;
    assign content_inc = 11'(p) * 11'(mr_cl);
    assign start_back  = 11'(p) * (11'(mr_cl) + 11'd1);
    assign mism        = (st.mismatch_count < MISMATCH_MAX) ?
                         st.mismatch_count + 9'd1 : st.mismatch_count;

    always_comb begin
        st_next   = st;
        res_valid = 1'b0;
        res       = '0;

        if (st.gen_pos > GPOS_W'(MEGABASE_LIMIT)) begin
            st_next.gen_pos   = '0;
            st_next.megabases = sat_add31(st.megabases, 31'd1);
        end
        if (c == CHAR_HEADER) begin
            st_next.in_header = 1'b1;
            st_next.rec_pos   = '0;
        end
        if (c == CHAR_NEWLINE && st_next.in_header)
            st_next.in_header = 1'b0;
        if (c != CHAR_NEWLINE && !st_next.in_header) begin
            st_next.gen_pos = st_next.gen_pos + GPOS_W'(1);
            st_next.rec_pos = st_next.rec_pos + 32'd1;
        end

        if (code != HIST_EMPTY && !st_next.in_header) begin
            st_next.hist = hist_new;

            if (st.run_active) begin
                if (p < 3'(MIN_PERIOD) || p > 3'(MAX_PERIOD)) begin
                    st_next.run_active = 1'b0;
                end else begin
                    st_next.phase_count = phase_inc;
                    if (phase_inc >= p) begin
                        st_next.phase_count = '0;
                        if (same_v[p]) begin
                            if (st.match_count == 31'(mr_cl)) begin
                                st_next.locus_length  = 31'(mr_cl);
                                st_next.locus_start   = st_next.rec_pos - 32'(start_back);
                                st_next.content_total =
                                    sat_add31(st.content_total, 31'(content_inc));
                                res_valid = 1'b1;
                                res.kind  = EV_OPEN;
                            end
                            if (st.match_count > 31'(mr_cl)) begin
                                st_next.locus_length  = sat_add31(st.locus_length, 31'd1);
                                st_next.content_total = sat_add31(st.content_total, 31'(p));
                                res_valid = 1'b1;
                                res.kind  = EV_EXTEND;
                            end
                            st_next.match_count = sat_add31(st.match_count, 31'd1);
                        end else begin
                            st_next.mismatch_count = mism;
                            st_next.phase_count    = p - 3'd1;
                            if (mism > {1'b0, field_byte(skip_tol, p)})
                                st_next.run_active = 1'b0;
                        end
                    end
                end
            end

            // shortest period wins: scan down so the smallest hit is last
            if (!st_next.run_active) begin
                for (int q = MAX_PERIOD; q >= MIN_PERIOD; q--) begin
                    if (rep_v[q]) begin
                        st_next.run_active     = 1'b1;
                        st_next.run_period     = 3'(q);
                        st_next.run_motif      = motif_v[q];
                        st_next.match_count    = 31'd2;
                        st_next.phase_count    = '0;
                        st_next.mismatch_count = '0;
                    end
                end
            end
        end

        res.period    = p;
        res.motif     = st.run_motif;
        res.start     = st_next.locus_start;
        res.length    = st_next.locus_length;
        res.content   = st_next.content_total;
        res.megabases = st_next.megabases;
    end

endmodule
`default_nettype wire

// ===== src/tandem_repeat_detector_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tandem_repeat_detector_top: short tandem repeat finder on FASTA text
// Folds case, tracks headers and positions, finds period 2..6 repeats in a
// 12-base history and reports locus openings and extensions.
// ---------------------------------------------------------------------------
//
//  channel   dir  width       beat contents
//  s_*       in   tdata 8     raw FASTA byte
//  m_*       out  tdata 144   period, motif, start, length, content, megabases
//                 tuser 1     event kind (0 open, 1 extend)
//  cfg_*     in   wdata 40    min repeats (0), skip tolerance (1)
//
//  One byte per cycle sustained while the result side accepts; a taken
//  byte loads the input register, and once the result slot is free its
//  result loads the result register.
//  The per-byte path is the parallel compare of the twelve-base history plus
//  the 31-bit counter updates, one register to the next.
//  aresetn is synchronous and clears all detector state.
//  m_tready low holds the result; one more byte waits in the input
//  register, after which s_tready drops.
// ---------------------------------------------------------------------------
module tandem_repeat_detector_top
    import trd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,

    input  wire logic         s_tvalid,
    output      logic         s_tready,
    input  wire logic [7:0]   s_tdata,     // [7:0] char_code

    output      logic         m_tvalid,
    input  wire logic         m_tready,
    output      logic [143:0] m_tdata,     // [2:0] motif_period, [14:3] motif_bases,
                                           // [46:15] start_location, [77:47] repeat_length,
                                           // [108:78] total_content, [139:109] megabase_count
    output      logic         m_tuser,     // [0] event_kind

    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    logic             in_valid_reg;
    logic [7:0]       in_char_reg;
    logic             out_valid_reg;
    trd_result_t      out_res_reg;
    trd_state_t       state_reg;
    logic [CFG_W-1:0] min_rep_reg;
    logic [CFG_W-1:0] skip_tol_reg;

    trd_state_t       state_next;
    logic             step_valid;
    trd_result_t      step_res;
    logic             advance;

    // Byte in the input register moves on when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    trd_step u_step (
        .char_code   (in_char_reg),
        .st          (state_reg),
        .min_repeats (min_rep_reg),
        .skip_tol    (skip_tol_reg),
        .st_next     (state_next),
        .res_valid   (step_valid),
        .res         (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            min_rep_reg   <= MIN_REPEATS_RESET;
            skip_tol_reg  <= SKIP_TOL_RESET;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MIN_REPEATS: min_rep_reg  <= cfg_wdata;
                    CFG_SKIP_TOL:    skip_tol_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= step_valid;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready)
            in_char_reg <= s_tdata;
        if (advance)
            out_res_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {4'd0,
                       out_res_reg.megabases,
                       out_res_reg.content,
                       out_res_reg.length,
                       out_res_reg.start,
                       out_res_reg.motif,
                       out_res_reg.period};

`ifndef ASSERT_OFF
    a_period_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.run_active |-> (state_reg.run_period >= 3'(MIN_PERIOD) &&
                                  state_reg.run_period <= 3'(MAX_PERIOD)))
        else $error("active run with bad period");

    a_phase_below_period: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.run_active |-> (state_reg.phase_count < state_reg.run_period))
        else $error("motif phase out of range");

    a_open_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.kind == EV_OPEN) |-> (out_res_reg.length >= 31'd2))
        else $error("locus opened below minimum count");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result appeared without a processed byte");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_tandem_repeat_detector_top.sv =====
// ---------------------------------------------------------------------------
// tb_tandem_repeat_detector_top: self-checking bench for the repeat detector
// Streams FASTA-like text into the block, predicts every locus open/extend
// beat from a cycle-free copy of the detector state, and checks each result
// beat field by field. Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_tandem_repeat_detector_top;
    import trd_pkg::*;

    localparam logic [7:0] CHAR_N = 8'h6E;   // 'n', a non-base letter

    // DUT ports; every input starts at a known value
    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'h00;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [143:0]     m_tdata;
    logic             m_tuser;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    tandem_repeat_detector_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #(30_000_000);
        $display("Mismatches found");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Predictor state: own copy of the detector and its two registers
    // -----------------------------------------------------------------------
    logic [CFG_W-1:0] min_rep_cfg = MIN_REPEATS_RESET;
    logic [CFG_W-1:0] tol_cfg     = SKIP_TOL_RESET;

    hist_code_t  base_hist [HIST_DEPTH];   // [0] newest
    logic        hdr_open;
    logic [31:0] rec_pos;
    logic [20:0] gen_pos;
    logic [30:0] mb_count;
    logic        tracking;
    logic [2:0]  trk_period;
    logic [11:0] trk_motif;
    logic [30:0] hit_count;
    logic [2:0]  phase;
    logic [8:0]  miss_count;
    logic [31:0] loc_start;
    logic [30:0] loc_len;
    logic [30:0] content_sum;

    trd_result_t locus_events_q [$];   // expected result beats, oldest first
    trd_result_t head_event;
    int          fail_count = 0;

    // Traffic shaping: quiet windows with no gaps / no stalls
    logic [15:0] cycle_no = '0;
    int          hold_left = 0;

    initial begin
        for (int k = 0; k < HIST_DEPTH; k++) base_hist[k] = HIST_EMPTY;
        hdr_open    = 1'b0;
        rec_pos     = '0;
        gen_pos     = '0;
        mb_count    = '0;
        tracking    = 1'b0;
        trk_period  = '0;
        trk_motif   = '0;
        hit_count   = '0;
        phase       = '0;
        miss_count  = '0;
        loc_start   = '0;
        loc_len     = '0;
        content_sum = '0;
    end

    function automatic logic [30:0] clip_sum(input logic [30:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {2'b00, a} + {1'b0, b};
        return (s > {2'b00, SAT31}) ? SAT31 : s[30:0];
    endfunction

    // Advance the predicted detector by one text byte; queue a beat if one fires
    function automatic void track_repeats(input logic [7:0] raw);
        logic [7:0]  ch;
        hist_code_t  code;
        logic [2:0]  p;
        logic [7:0]  min_rep;
        logic [11:0] m;
        logic [2:0]  dec;
        logic        same;
        logic        rep;
        logic        fire;
        trd_result_t res;
        int          j;
        int          q;

        ch   = raw;
        fire = 1'b0;
        res  = '0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ch = ch + CASE_OFFSET;

        if (gen_pos > MEGABASE_LIMIT) begin
            gen_pos  = '0;
            mb_count = clip_sum(mb_count, 32'd1);
        end
        if (ch == CHAR_HEADER) begin
            hdr_open = 1'b1;
            rec_pos  = '0;
        end
        if (ch == CHAR_NEWLINE && hdr_open) hdr_open = 1'b0;
        if (ch != CHAR_NEWLINE && !hdr_open) begin
            gen_pos = gen_pos + 21'd1;
            rec_pos = rec_pos + 32'd1;
        end

        case (ch)
            CHAR_A:  code = HIST_A;
            CHAR_C:  code = HIST_C;
            CHAR_G:  code = HIST_G;
            CHAR_T:  code = HIST_T;
            default: code = HIST_EMPTY;
        endcase
        if (code == HIST_EMPTY || hdr_open) return;

        for (j = HIST_DEPTH - 1; j > 0; j--) base_hist[j] = base_hist[j-1];
        base_hist[0] = code;

        if (tracking) begin
            p = trk_period;
            if (p < MIN_PERIOD || p > MAX_PERIOD) begin
                tracking = 1'b0;
            end else begin
                phase = phase + 3'd1;
                if (phase >= p) begin
                    phase = '0;
                    same  = 1'b1;
                    for (j = 0; j < p; j++)
                        if (base_hist[p+j] != {1'b0, trk_motif[2*(p-1-j) +: 2]} + 3'd1)
                            same = 1'b0;
                    if (same) begin
                        min_rep = min_rep_cfg[(p-2)*8 +: 8];
                        if (min_rep < 8'd2) min_rep = 8'd2;
                        if (hit_count == {23'd0, min_rep}) begin
                            loc_len     = {23'd0, min_rep};
                            loc_start   = rec_pos - 32'(p) * (32'(min_rep) + 32'd1);
                            content_sum = clip_sum(content_sum, 32'(p) * 32'(min_rep));
                            res.kind    = EV_OPEN;
                            fire        = 1'b1;
                        end
                        if (hit_count > {23'd0, min_rep}) begin
                            loc_len     = clip_sum(loc_len, 32'd1);
                            content_sum = clip_sum(content_sum, 32'(p));
                            res.kind    = EV_EXTEND;
                            fire        = 1'b1;
                        end
                        hit_count = clip_sum(hit_count, 32'd1);
                    end else begin
                        if (miss_count < MISMATCH_MAX) miss_count = miss_count + 9'd1;
                        phase = p - 3'd1;
                        if (miss_count > {1'b0, tol_cfg[(p-2)*8 +: 8]}) tracking = 1'b0;
                    end
                    if (fire) begin
                        res.period    = p;
                        res.motif     = trk_motif;
                        res.start     = loc_start;
                        res.length    = loc_len;
                        res.content   = content_sum;
                        res.megabases = mb_count;
                        locus_events_q.push_back(res);
                    end
                end
            end
        end

        // look for a fresh doubled unit at the newest end, shortest period first
        if (!tracking) begin
            for (q = MIN_PERIOD; q <= MAX_PERIOD && !tracking; q++) begin
                rep = 1'b1;
                for (j = 0; j < q; j++)
                    if (base_hist[j] != base_hist[j+q]) rep = 1'b0;
                if (rep) begin
                    m = '0;
                    for (j = 0; j < q; j++) begin
                        dec = base_hist[q-1-j] - 3'd1;
                        m[2*j +: 2] = dec[1:0];
                    end
                    tracking   = 1'b1;
                    trk_period = 3'(q);
                    trk_motif  = m;
                    hit_count  = 31'd2;
                    phase      = '0;
                    miss_count = '0;
                end
            end
        end
    endfunction

    // -----------------------------------------------------------------------
    // Result side: random back-pressure and the beat checker
    // -----------------------------------------------------------------------
    // Mostly short gaps, a few long ones
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // m_tready: stalls of random length; one window in four starts no new stall
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 16'd1;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (cycle_no[9:8] != 2'b01 && $urandom_range(0, 99) < 20) begin
            hold_left = gap_length() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void compare_field(input string label, input logic [31:0] want_v,
                                          input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, label, want_v, got_v);
            fail_count++;
        end
    endfunction

    // Every result beat must match the oldest predicted event
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (locus_events_q.size() == 0) begin
                $display("%0t: result beat with none expected, expected nothing actual %h/%0d",
                         $time, m_tdata, m_tuser);
                fail_count++;
            end else begin
                head_event = locus_events_q.pop_front();
                compare_field("event_kind",     32'(head_event.kind),      32'(m_tuser));
                compare_field("motif_period",   32'(head_event.period),    32'(m_tdata[2:0]));
                compare_field("motif_bases",    32'(head_event.motif),     32'(m_tdata[14:3]));
                compare_field("start_location", head_event.start,          m_tdata[46:15]);
                compare_field("repeat_length",  32'(head_event.length),    32'(m_tdata[77:47]));
                compare_field("total_content",  32'(head_event.content),   32'(m_tdata[108:78]));
                compare_field("megabase_count", 32'(head_event.megabases), 32'(m_tdata[139:109]));
                compare_field("tdata_pad",      32'd0,                     32'(m_tdata[143:140]));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Input side
    // -----------------------------------------------------------------------
    // One text beat. s_tvalid stays high between back-to-back beats and is
    // only lowered when a gap is taken, so it never sees two NBAs in a step.
    task automatic send_byte(input logic [7:0] ch);
        int gap;
        gap = (cycle_no[8:7] == 2'b00 || $urandom_range(0, 1) == 0) ? 0 : gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_repeats(ch);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Stop input and let every predicted beat come out, then cover the
    // input and result registers in case the last bytes were still in flight
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (locus_events_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_MIN_REPEATS) min_rep_cfg = value;
        else tol_cfg = value;
    endtask

    function automatic logic [7:0] base_char(input logic [1:0] b);
        case (b)
            2'd0:    return CHAR_A;
            2'd1:    return CHAR_C;
            2'd2:    return CHAR_G;
            default: return CHAR_T;
        endcase
    endfunction

    // Five per-period bytes, each drawn from lo..hi
    function automatic logic [CFG_W-1:0] per_period_bytes(input int lo, input int hi);
        logic [CFG_W-1:0] v;
        for (int i = 0; i < 5; i++) v[8*i +: 8] = 8'($urandom_range(lo, hi));
        return v;
    endfunction

    // FASTA-like text: mostly tandem units with random content and the odd
    // substitution, plus headers, stray bases, newlines and raw noise
    task automatic send_fasta_like(input int n_items);
        int         sent;
        int         pick;
        int         period;
        int         copies;
        int         i;
        logic [1:0] unit [6];
        logic [7:0] ch;

        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                period = $urandom_range(2, 6);
                copies = $urandom_range(2, 12);
                for (i = 0; i < period; i++) unit[i] = 2'($urandom_range(0, 3));
                for (i = 0; i < copies * period; i++) begin
                    if ($urandom_range(0, 99) < 5) ch = base_char(2'($urandom_range(0, 3)));
                    else ch = base_char(unit[i % period]);
                    if ($urandom_range(0, 99) < 30) ch = ch - CASE_OFFSET;
                    send_byte(ch);
                    sent++;
                    if ($urandom_range(0, 99) < 3) begin
                        send_byte($urandom_range(0, 1) ? CHAR_N : CHAR_NEWLINE);
                        sent++;
                    end
                end
            end else if (pick < 80) begin
                for (i = $urandom_range(1, 8); i > 0; i--) begin
                    send_byte(base_char(2'($urandom_range(0, 3))));
                    sent++;
                end
            end else if (pick < 88) begin
                send_byte(CHAR_HEADER);
                for (i = $urandom_range(0, 6); i > 0; i--) begin
                    ch = 8'($urandom_range(0, 255));
                    if (ch == CHAR_NEWLINE) ch = CHAR_N;
                    send_byte(ch);
                end
                send_byte(CHAR_NEWLINE);
                sent++;
            end else if (pick < 95) begin
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end else begin
                send_byte(CHAR_NEWLINE);
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    // Minimum 0 clamps to 2 per period, so short runs already open a locus.
    // Upper case folds, and 'n', 0x00, 0xFF only move the positions.
    task automatic test_case_and_noise();
        write_reg(CFG_MIN_REPEATS, '0);
        write_reg(CFG_SKIP_TOL, '0);
        send_text("ACaCac");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("Nac");
    endtask

    // A header resets the record position but keeps history and the run
    task automatic test_headers();
        send_text(">h\nac");
    endtask

    // Zero tolerance: the first mismatch ends the run and detection restarts
    // on that same base
    task automatic test_end_restart();
        send_text("agtagtagt");
    endtask

    // Raise the minimum so no locus opens, then lower it mid-run: the run
    // extends the held locus without an opening
    task automatic test_extend_without_open();
        write_reg(CFG_MIN_REPEATS, {5{8'd9}});
        send_text("acacacac");
        write_reg(CFG_MIN_REPEATS, '0);
        send_text("ac");
    endtask

    // Extremes of both registers
    task automatic test_extreme_settings();
        write_reg(CFG_MIN_REPEATS, '0);
        write_reg(CFG_SKIP_TOL, '0);
        send_fasta_like(250);
        write_reg(CFG_MIN_REPEATS, {CFG_W{1'b1}});
        write_reg(CFG_SKIP_TOL, {CFG_W{1'b1}});
        send_fasta_like(100);
        write_reg(CFG_MIN_REPEATS, {5{8'd1}});
        send_fasta_like(200);
    endtask

    // Mixed per-period settings, then back to the reset values
    task automatic test_random_settings();
        for (int k = 0; k < 3; k++) begin
            write_reg(CFG_MIN_REPEATS, per_period_bytes(0, 8));
            write_reg(CFG_SKIP_TOL, per_period_bytes(0, 3));
            send_fasta_like(320);
        end
        write_reg(CFG_MIN_REPEATS, MIN_REPEATS_RESET);
        write_reg(CFG_SKIP_TOL, SKIP_TOL_RESET);
        send_fasta_like(300);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_case_and_noise();
        test_headers();
        test_end_restart();
        test_extend_without_open();
        test_extreme_settings();
        test_random_settings();

        settle_block();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/trd_pkg.sv
src/trd_step.sv
src/tandem_repeat_detector_top.sv
tb/tb_tandem_repeat_detector_top.sv
